>>> rtl/rgb_gradient_energy_core_macros.svh
// ----------------------------------------------------------------------------
// RGB gradient energy: assertion macros
// Concurrent checks on clk_i, held off while rst_ni is low. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_GRADIENT_ENERGY_CORE_MACROS_SVH
`define RGB_GRADIENT_ENERGY_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RGE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("rge: assertion failed");
`define RGE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rge: assertion failed");
`else
`define RGE_ASSERT_ALWAYS(lbl, expr)
`define RGE_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

>>> rtl/rge_pkg.sv
// ----------------------------------------------------------------------------
// RGB gradient energy: shared package
// Widths, register indexes, luma weights, flag struct and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package rge_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned RGB_W          = 8;
  localparam int unsigned LUMA_W         = 16;
  localparam int unsigned ENERGY_W       = 17;
  localparam int unsigned SQ_W           = 32;   // one square, |d| < 2^16
  localparam int unsigned RAD_W          = 33;   // sum of two squares

  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned WIDTH_REG_W    = 11;
  localparam int unsigned HEIGHT_REG_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  // luma fraction bits, Q0.16 weights
  localparam int unsigned LUMA_FRAC_BITS = 8;
  localparam int unsigned LUMA_SHIFT     = 16 - LUMA_FRAC_BITS;
  localparam int unsigned ACC_W          = 25;
  localparam logic [ACC_W-1:0] W_RED     = 25'd13933;
  localparam logic [ACC_W-1:0] W_GREEN   = 25'd46872;
  localparam logic [ACC_W-1:0] W_BLUE    = 25'd4732;

  typedef struct packed {
    logic emit;       // a result belongs to this transaction
    logic use_up;     // row above is inside the image
    logic use_left;   // left neighbour is inside the image
    logic use_right;  // right neighbour is inside the image
    logic last;       // bottom-right pixel
  } rge_flags_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_SQUARE,
    ST_START,
    ST_SQRT,
    ST_OUT
  } rge_state_e;

  // weighted sum, round half up, saturate
  function automatic logic [LUMA_W-1:0] rgb_to_luma(input logic [RGB_W-1:0] r,
                                                    input logic [RGB_W-1:0] g,
                                                    input logic [RGB_W-1:0] b);
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] shifted;
    acc = W_RED * ACC_W'(r) + W_GREEN * ACC_W'(g) + W_BLUE * ACC_W'(b);
    shifted = (acc + (ACC_W'(1) << (LUMA_SHIFT - 1))) >> LUMA_SHIFT;
    if (shifted > ACC_W'(16'hFFFF)) begin
      return {LUMA_W{1'b1}};
    end
    return shifted[LUMA_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rgb_gradient_energy_core.sv
// ----------------------------------------------------------------------------
// RGB gradient energy core
// Streaming luma conversion and central-difference gradient magnitude.
// ----------------------------------------------------------------------------
// Takes RGB pixels in raster order, turns each into Q8.8 luma with the
// weights 0.2126 / 0.7152 / 0.0722 and returns sqrt(dx^2 + dy^2) per pixel,
// rounded to nearest, neighbours outside the image counting as zero. Results
// run one row behind the input: the result for (r, c) leaves with the
// transaction for (r+1, c), so row zero gives none. A last row of
// transactions (flush ticks, tuser = 1, or pixels, whose data is then
// dropped) drains the bottom row; tlast marks its bottom-right result. A
// flush tick outside that drain row is dropped silently. After reset the
// core zeroes its two line stores, one entry a cycle, with s_axis_tready
// low; register writes are taken throughout. Registers are written on
// cfg_we_i; width is used clamped to 2..MAX_WIDTH, height to at least 2,
// and they must only change while the core is idle. The front end accepts
// one transaction a cycle into a four-entry command queue while it has
// room; the back end works through one command at a time: line-store read
// and differences, then, for a command that gives a result, squares, a
// 17-step bit-serial square root and a hand-over to the output register,
// which waits while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_gradient_energy_core_macros.svh"

module rgb_gradient_energy_core #(
  parameter int unsigned MAX_WIDTH = rge_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [rge_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rge_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixel input
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [23:0]                     s_axis_tdata,  // red, green, blue
  input  wire logic                            s_axis_tuser,  // mode
  // energy output
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // energy, zero pad
  output logic                                 m_axis_tlast   // last_of_image
);
  import rge_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_WIDTH);
  localparam int unsigned FLAG_W = $bits(rge_flags_t);
  localparam int unsigned CMD_W  = 2 * IDX_W + LUMA_W + FLAG_W;

  logic                clearing;

  // front end to queue
  logic                push_valid, push_ready;
  logic [IDX_W-1:0]    push_col, push_col_next;
  logic [LUMA_W-1:0]   push_lum;
  rge_flags_t          push_flags;

  // queue to back end
  logic                q_pop, q_pop_valid;
  logic [CMD_W-1:0]    q_data;
  logic [IDX_W-1:0]    q_col, q_col_next;
  logic [LUMA_W-1:0]   q_lum;
  rge_flags_t          q_flags;

  logic [ENERGY_W-1:0] energy;

  rge_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .clear_busy_i    (clearing),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_o       (s_axis_tready),
    .s_mode_i        (s_axis_tuser),
    .s_red_i         (s_axis_tdata[7:0]),
    .s_green_i       (s_axis_tdata[15:8]),
    .s_blue_i        (s_axis_tdata[23:16]),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_col_o      (push_col),
    .push_col_next_o (push_col_next),
    .push_lum_o      (push_lum),
    .push_flags_o    (push_flags)
  );

  // command word: flags, luma, next column, column (column lowest)
  rge_queue #(
    .DATA_W (CMD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_flags, push_lum, push_col_next, push_col}),
    .pop_i        (q_pop),
    .pop_valid_o  (q_pop_valid),
    .pop_data_o   (q_data)
  );

  assign {q_flags, q_lum, q_col_next, q_col} = q_data;

  rge_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_o   (clearing),
    .q_valid_i    (q_pop_valid),
    .q_pop_o      (q_pop),
    .q_col_i      (q_col),
    .q_col_next_i (q_col_next),
    .q_lum_i      (q_lum),
    .q_flags_i    (q_flags),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_energy_o   (energy),
    .m_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, energy};

  // nothing enters while the line stores are being zeroed
  `RGE_ASSERT_ALWAYS(a_no_take_while_clearing, !(clearing && s_axis_tready))
  // the back end only takes a command that is there
  `RGE_ASSERT_IMPLIES(a_pop_needs_entry, q_pop, q_pop_valid)
  // root of two 16-bit squares never exceeds 92681
  `RGE_ASSERT_IMPLIES(a_energy_bound, m_axis_tvalid, energy <= 17'd92681)

endmodule

`default_nettype wire

>>> rtl/rge_front.sv
// ----------------------------------------------------------------------------
// RGB gradient energy: front end
// Holds the registers and raster counters, classifies each transaction and
// hands a command with its luma to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rge_front #(
  parameter int unsigned MAX_WIDTH = rge_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rge_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [rge_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                clear_busy_i,
  input  wire logic                                s_valid_i,
  output logic                                     s_ready_o,
  input  wire logic                                s_mode_i,
  input  wire logic [rge_pkg::RGB_W-1:0]           s_red_i,
  input  wire logic [rge_pkg::RGB_W-1:0]           s_green_i,
  input  wire logic [rge_pkg::RGB_W-1:0]           s_blue_i,
  output logic                                     push_valid_o,
  input  wire logic                                push_ready_i,
  output logic [$clog2(MAX_WIDTH)-1:0]             push_col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]             push_col_next_o,
  output logic [rge_pkg::LUMA_W-1:0]               push_lum_o,
  output rge_pkg::rge_flags_t                      push_flags_o
);
  import rge_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_WIDTH);
  localparam int unsigned WE_W  = IDX_W + 1;
  localparam int unsigned CW    = (WE_W > WIDTH_REG_W) ? WE_W : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [IDX_W-1:0]        col_q, col_d;
  logic [HEIGHT_REG_W-1:0] row_q, row_d;

  logic [WE_W-1:0]         w_eff;
  logic [IDX_W-1:0]        last_col, c, c_inc;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic                    drain, at_end, accept, take;

  logic                    stg_valid_q, stg_valid_d;
  logic                    stg_drain_q;
  logic [RGB_W-1:0]        stg_r_q, stg_g_q, stg_b_q;
  logic [IDX_W-1:0]        stg_col_q, stg_col_next_q;
  rge_flags_t              stg_flags_q, flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers, locate the transaction
  always_comb begin
    if (CW'(width_q) > CW'(MAX_WIDTH)) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else if (width_q < WIDTH_REG_W'(2)) begin
      w_eff = WE_W'(2);
    end else begin
      w_eff = WE_W'(width_q);
    end
    last_col = IDX_W'(w_eff - WE_W'(1));
    c        = ({1'b0, col_q} >= w_eff) ? last_col : col_q;
    c_inc    = c + IDX_W'(1);
    at_end   = (c == last_col);
    h_eff    = (height_q < HEIGHT_REG_W'(2)) ? HEIGHT_REG_W'(2) : height_q;
    drain    = (row_q >= h_eff);

    flags.emit      = (row_q != '0);
    flags.use_up    = (row_q != HEIGHT_REG_W'(1));
    flags.use_left  = (c != '0);
    flags.use_right = !at_end;
    flags.last      = drain && at_end;

    s_ready_o = !clear_busy_i && (!stg_valid_q || push_ready_i);
    accept    = s_valid_i && s_ready_o;
    // a flush tick outside the drain phase is dropped
    take      = accept && !(s_mode_i && !drain);

    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (at_end) begin
        col_d = '0;
        row_d = drain ? '0 : row_q + HEIGHT_REG_W'(1);
      end else begin
        col_d = c_inc;
      end
    end

    if (take) begin
      stg_valid_d = 1'b1;
    end else if (push_ready_i) begin
      stg_valid_d = 1'b0;
    end else begin
      stg_valid_d = stg_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_drain_q    <= drain;
      stg_r_q        <= s_red_i;
      stg_g_q        <= s_green_i;
      stg_b_q        <= s_blue_i;
      stg_col_q      <= c;
      stg_col_next_q <= c_inc;
      stg_flags_q    <= flags;
    end
  end

  // drain-phase data is discarded: luma counts as zero
  assign push_valid_o    = stg_valid_q;
  assign push_col_o      = stg_col_q;
  assign push_col_next_o = stg_col_next_q;
  assign push_flags_o    = stg_flags_q;
  assign push_lum_o      = stg_drain_q ? '0 : rgb_to_luma(stg_r_q, stg_g_q, stg_b_q);

endmodule

`default_nettype wire

>>> rtl/rge_queue.sv
// ----------------------------------------------------------------------------
// RGB gradient energy: command queue
// Small FIFO between front and back end, depth a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module rge_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = rge_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire logic [DATA_W-1:0] push_data_i,
  input  wire logic              pop_i,
  output logic                   pop_valid_o,
  output logic [DATA_W-1:0]      pop_data_o
);
  import rge_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]    count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != (PTR_W+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rge_sqrt.sv
// ----------------------------------------------------------------------------
// RGB gradient energy: square root unit
// Restoring digit-by-digit root, one result bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module rge_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rge_pkg::RAD_W-1:0]     radicand_i,
  output logic                               done_o,
  output logic [rge_pkg::ENERGY_W-1:0]       root_o
);
  import rge_pkg::*;

  localparam int unsigned PAD_W  = 2 * ENERGY_W;   // even width, holds RAD_W
  localparam int unsigned REM_W  = ENERGY_W + 3;
  localparam int unsigned CNT_W  = $clog2(ENERGY_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PAD_W-1:0] rad_q;
  logic [REM_W-1:0] rem_q, rem_sh, trial, rem_d;
  logic [ENERGY_W-1:0] root_q, root_d;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[PAD_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ENERGY_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ENERGY_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last digit
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(ENERGY_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ENERGY_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= PAD_W'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  // remainder above the root means the value lies past the half step
  assign done_o = done_q;
  assign root_o = root_q + ENERGY_W'(rem_q > REM_W'(root_q));

endmodule

`default_nettype wire

>>> rtl/rge_back.sv
// ----------------------------------------------------------------------------
// RGB gradient energy: back end
// Line stores, neighbour window, differences, squares and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rge_back #(
  parameter int unsigned MAX_WIDTH = rge_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               clearing_o,
  input  wire logic                          q_valid_i,
  output logic                               q_pop_o,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_col_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_col_next_i,
  input  wire logic [rge_pkg::LUMA_W-1:0]    q_lum_i,
  input  wire rge_pkg::rge_flags_t           q_flags_i,
  output logic                               m_valid_o,
  input  wire logic                          m_ready_i,
  output logic [rge_pkg::ENERGY_W-1:0]       m_energy_o,
  output logic                               m_last_o
);
  import rge_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_WIDTH);
  localparam int unsigned DIF_W = LUMA_W + 1;

  rge_state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  // line store a: middle row, line store b: row above it
  logic [LUMA_W-1:0] mem_a [MAX_WIDTH];
  logic [LUMA_W-1:0] mem_b [MAX_WIDTH];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LUMA_W-1:0] mem_wdata_a, mem_wdata_b;
  logic [LUMA_W-1:0] mid_q, right_q, up_q;

  logic [IDX_W-1:0]  col_q, col_next_q;
  logic [LUMA_W-1:0] lum_q;
  rge_flags_t        flags_q;
  logic              cmd_load;

  logic [LUMA_W-1:0] window_q;
  logic [LUMA_W-1:0] left, right, up;
  logic signed [DIF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [2*DIF_W-1:0] px, py;
  logic [SQ_W-1:0]   sq_x_q, sq_y_q;
  logic              calc_load, sq_load, sqrt_start, sqrt_done;
  logic [RAD_W-1:0]  radicand;
  logic [ENERGY_W-1:0] sqrt_root, res_q;
  logic              res_load, out_load;

  logic                m_valid_q, m_valid_d;
  logic [ENERGY_W-1:0] m_energy_q;
  logic                m_last_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    q_pop_o     = 1'b0;
    cmd_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = col_q;
    mem_wdata_a = lum_q;
    mem_wdata_b = mid_q;
    calc_load   = 1'b0;
    sq_load     = 1'b0;
    sqrt_start  = 1'b0;
    res_load    = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_q;
        mem_wdata_a = '0;
        mem_wdata_b = '0;
        clr_d       = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(MAX_WIDTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          cmd_load = 1'b1;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        mem_we    = 1'b1;
        calc_load = 1'b1;
        state_d   = flags_q.emit ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        sq_load = 1'b1;
        state_d = ST_START;
      end
      ST_START: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          res_load = 1'b1;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_a[mem_waddr] <= mem_wdata_a;
      mem_b[mem_waddr] <= mem_wdata_b;
    end
    mid_q   <= mem_a[col_q];
    right_q <= mem_a[col_next_q];
    up_q    <= mem_b[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_load) begin
      col_q      <= q_col_i;
      col_next_q <= q_col_next_i;
      lum_q      <= q_lum_i;
      flags_q    <= q_flags_i;
    end
  end

  // neighbours outside the image are zero
  always_comb begin
    left  = flags_q.use_left  ? window_q : '0;
    right = flags_q.use_right ? right_q  : '0;
    up    = flags_q.use_up    ? up_q     : '0;
    dx_d  = $signed({1'b0, left}) - $signed({1'b0, right});
    dy_d  = $signed({1'b0, up}) - $signed({1'b0, lum_q});
    px    = dx_q * dx_q;
    py    = dy_q * dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (calc_load) begin
      window_q <= mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_load) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (sq_load) begin
      sq_x_q <= px[SQ_W-1:0];
      sq_y_q <= py[SQ_W-1:0];
    end
    if (res_load) begin
      res_q <= sqrt_root;
    end
  end

  assign radicand = RAD_W'(sq_x_q) + RAD_W'(sq_y_q);

  rge_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // result register parts the back end from the output channel
  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_energy_q <= res_q;
      m_last_q   <= flags_q.last;
    end
  end

  assign clearing_o = (state_q == ST_CLEAR);
  assign m_valid_o  = m_valid_q;
  assign m_energy_o = m_energy_q;
  assign m_last_o   = m_last_q;

endmodule

`default_nettype wire
